[src/wfrc_pkg.sv]
// Shared types, codes and constants of the wall-follow reactive controller.
package wfrc_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int THR_W       = 12;
  localparam int SPEED_W     = 10;
  localparam int LOSE_W      = 8;
  localparam int ESC_W       = 4;
  localparam int OUT_SPEED_W = 11;
  localparam int OUT_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  localparam logic [THR_W-1:0]   FRONT_THR_RST  = 12'd150;
  localparam logic [THR_W-1:0]   SIDE_THR_RST   = 12'd200;
  localparam logic [SPEED_W-1:0] FULL_SPEED_RST = 10'd1000;
  localparam logic [LOSE_W-1:0]  LOSE_RST       = 8'd40;
  localparam logic [ESC_W-1:0]   ESC_RST        = 4'd5;

  localparam int SENSOR_FRONT_RIGHT = 0;
  localparam int SENSOR_DIAG_RIGHT  = 1;
  localparam int SENSOR_SIDE_RIGHT  = 2;
  localparam int SENSOR_SIDE_LEFT   = 5;
  localparam int SENSOR_DIAG_LEFT   = 6;
  localparam int SENSOR_FRONT_LEFT  = 7;

  typedef enum logic [2:0] {
    REG_FRONT_THR  = 3'd0,
    REG_SIDE_THR   = 3'd1,
    REG_FULL_SPEED = 3'd2,
    REG_LOSE_WALL  = 3'd3,
    REG_ESCAPE     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    LAYER_ESCAPE   = 3'd0,
    LAYER_CORNER   = 3'd1,
    LAYER_OBSTACLE = 3'd2,
    LAYER_SEEK     = 3'd3,
    LAYER_CRUISE   = 3'd4
  } layer_t;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef struct packed {
    logic [THR_W-1:0]   front_thr;
    logic [THR_W-1:0]   side_thr;
    logic [SPEED_W-1:0] full_speed;
    logic [LOSE_W-1:0]  lose_wall;
    logic [ESC_W-1:0]   escape;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0] is_max;
    logic [NUM_SENSORS-1:0] above;
    logic                   front_right_gt;
    logic                   left_sum_gt;
  } lane_flags_t;

endpackage

[src/wfrc_lane.sv]
// One sensor lane: maximum test against all samples and threshold test.
module wfrc_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0]   own_sample,
  input  logic [8*SAMPLE_BITS-1:0] all_samples,
  input  logic [11:0]              threshold,
  output logic                     is_max,
  output logic                     above
);
  import wfrc_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [NUM_SENSORS-1:0] not_less;

  always_comb begin
    for (int j = 0; j < NUM_SENSORS; j++) begin
      not_less[j] = (own_sample >= all_samples[j*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  assign is_max = &not_less;
  assign above  = (CMP_W'(own_sample) > CMP_W'(threshold));

endmodule

[src/wfrc_merge.sv]
// Merge stage: layer priority, controller state and the output register.
module wfrc_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  wfrc_pkg::lane_flags_t         flags,
  input  wfrc_pkg::cfg_t                cfg,
  output logic                          s2_ready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_tdata: left_speed[10:0], right_speed[21:11], wall_side[23:22],
  // acting_layer[26:24], zero fill [31:27]
  output logic [wfrc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wfrc_pkg::*;

  logic [ESC_W-1:0]       escape_r, escape_nxt;
  logic [LOSE_W-1:0]      lost_r, lost_nxt;
  side_t                  side_r, side_nxt, side_cur;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   fire;

  logic [17:0]            p1;
  logic [27:0]            p8;
  logic [6:0]             t1;
  logic [8:0]             t5;
  logic [9:0]             t8;
  logic [OUT_SPEED_W-1:0] full, v1, v5, v8, left, right;
  layer_t                 layer;
  logic [2:0]             first_max;
  logic                   found;

  assign s2_ready = !out_valid_r || out_tready;
  assign fire     = s1_valid && s2_ready;

  assign p1   = 18'(cfg.full_speed) * 18'd205;
  assign p8   = 28'({cfg.full_speed, 2'b00}) * 28'd52429;
  assign t1   = p1[17:11];
  assign t8   = p8[27:18];
  assign t5   = cfg.full_speed[SPEED_W-1:1];
  assign full = {1'b0, cfg.full_speed};
  assign v1   = {4'b0, t1};
  assign v5   = {2'b0, t5};
  assign v8   = {1'b0, t8};

  always_comb begin
    found     = 1'b0;
    first_max = 3'd7;
    for (int i = 0; i < NUM_SENSORS - 1; i++) begin
      if (!found && flags.is_max[i]) begin
        found     = 1'b1;
        first_max = 3'(i);
      end
    end
  end

  always_comb begin
    escape_nxt = escape_r;
    lost_nxt   = lost_r;
    side_cur   = side_r;
    layer      = LAYER_SEEK;
    left       = full;
    right      = full;
    if (escape_r != '0 || (flags.above[SENSOR_FRONT_RIGHT] && flags.above[SENSOR_FRONT_LEFT]))
    begin
      if (escape_r != '0) begin
        escape_nxt = escape_r - 1'b1;
        layer      = LAYER_ESCAPE;
      end else begin
        escape_nxt = (cfg.escape == '0) ? '0 : cfg.escape - 1'b1;
        layer      = LAYER_CORNER;
      end
      if (flags.left_sum_gt) begin
        left  = full;
        right = -full;
      end else begin
        left  = -full;
        right = full;
      end
    end else if (flags.above[SENSOR_FRONT_RIGHT] || flags.above[SENSOR_FRONT_LEFT]) begin
      layer = LAYER_OBSTACLE;
      if (flags.front_right_gt) begin
        left  = -v8;
        right = v8;
      end else begin
        left  = v8;
        right = -v8;
      end
    end else if (flags.is_max[SENSOR_SIDE_RIGHT] && flags.above[SENSOR_SIDE_RIGHT]) begin
      side_cur = SIDE_RIGHT;
      lost_nxt = cfg.lose_wall;
      layer    = LAYER_CRUISE;
    end else if (flags.is_max[SENSOR_SIDE_LEFT] && flags.above[SENSOR_SIDE_LEFT]) begin
      side_cur = SIDE_LEFT;
      lost_nxt = cfg.lose_wall;
      layer    = LAYER_CRUISE;
    end else begin
      if (lost_r != '0) begin
        lost_nxt = lost_r - 1'b1;
      end
      layer = LAYER_SEEK;
      case (first_max)
        3'd0: begin left = full; right = v8;   end
        3'd1: begin left = full; right = v5;   end
        3'd2: begin left = full; right = v1;   end
        3'd5: begin left = v1;   right = full; end
        3'd6: begin left = v5;   right = full; end
        3'd7: begin left = v8;   right = full; end
        default: begin left = full; right = full; end
      endcase
    end
    side_nxt     = (lost_nxt == '0) ? SIDE_NONE : side_cur;
    out_data_nxt = {5'b0, layer, side_nxt, right, left};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r    <= '0;
      lost_r      <= LOSE_RST;
      side_r      <= SIDE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        escape_r <= escape_nxt;
        lost_r   <= lost_nxt;
        side_r   <= side_nxt;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[src/wall_follow_reactive_controller_top.sv]
// Wall-follow reactive controller: config port, sensor lanes, merge stage.
// An accepted input word passes the flags register, then the output register.
// Throughput: 1 word per cycle while out_tready is high; eight comparison lanes and one merge stage.
// Reset (rst_n low, synchronous): pipeline empties, config registers and
// controller state return to their defaults.
module wall_follow_reactive_controller_top #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: prox_front_right, prox_diag_right, prox_side_right,
  // prox_back_right, prox_back_left, prox_side_left, prox_diag_left,
  // prox_front_left, SAMPLE_BITS each, lowest first
  input  logic [8*SAMPLE_BITS-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: left_speed[10:0], right_speed[21:11], wall_side[23:22],
  // acting_layer[26:24], zero fill [31:27]
  output logic [wfrc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wfrc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wfrc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wfrc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import wfrc_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 2;

  cfg_t        cfg_r;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  lane_flags_t flags_nxt, flags_r;
  logic        s1_valid_r;
  logic        s2_ready;
  logic [SUM_W-1:0] sum_left, sum_right;
  logic [11:0] lane_thr [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] lane_is_max, lane_above;
  logic        left_sum_gt, front_right_gt;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.front_thr  <= FRONT_THR_RST;
      cfg_r.side_thr   <= SIDE_THR_RST;
      cfg_r.full_speed <= FULL_SPEED_RST;
      cfg_r.lose_wall  <= LOSE_RST;
      cfg_r.escape     <= ESC_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRONT_THR:  cfg_r.front_thr  <= cfg_pwdata[THR_W-1:0];
        REG_SIDE_THR:   cfg_r.side_thr   <= cfg_pwdata[THR_W-1:0];
        REG_FULL_SPEED: cfg_r.full_speed <= cfg_pwdata[SPEED_W-1:0];
        REG_LOSE_WALL:  cfg_r.lose_wall  <= cfg_pwdata[LOSE_W-1:0];
        REG_ESCAPE:     cfg_r.escape     <= cfg_pwdata[ESC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRONT_THR:  cfg_prdata = CFG_DATA_W'(cfg_r.front_thr);
      REG_SIDE_THR:   cfg_prdata = CFG_DATA_W'(cfg_r.side_thr);
      REG_FULL_SPEED: cfg_prdata = CFG_DATA_W'(cfg_r.full_speed);
      REG_LOSE_WALL:  cfg_prdata = CFG_DATA_W'(cfg_r.lose_wall);
      REG_ESCAPE:     cfg_prdata = CFG_DATA_W'(cfg_r.escape);
      default:        cfg_prdata = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      lane_thr[i] = ((i == SENSOR_SIDE_RIGHT) || (i == SENSOR_SIDE_LEFT)) ?
                    cfg_r.side_thr : cfg_r.front_thr;
    end
  end

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    wfrc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .own_sample  (in_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
      .all_samples (in_tdata),
      .threshold   (lane_thr[g]),
      .is_max      (lane_is_max[g]),
      .above       (lane_above[g])
    );
  end

  assign sum_left =
    SUM_W'(in_tdata[SENSOR_FRONT_LEFT*SAMPLE_BITS +: SAMPLE_BITS]) +
    SUM_W'(in_tdata[SENSOR_DIAG_LEFT*SAMPLE_BITS +: SAMPLE_BITS]) +
    SUM_W'(in_tdata[SENSOR_SIDE_LEFT*SAMPLE_BITS +: SAMPLE_BITS]);
  assign sum_right =
    SUM_W'(in_tdata[SENSOR_FRONT_RIGHT*SAMPLE_BITS +: SAMPLE_BITS]) +
    SUM_W'(in_tdata[SENSOR_DIAG_RIGHT*SAMPLE_BITS +: SAMPLE_BITS]) +
    SUM_W'(in_tdata[SENSOR_SIDE_RIGHT*SAMPLE_BITS +: SAMPLE_BITS]);

  assign left_sum_gt    = (sum_left > sum_right);
  assign front_right_gt =
    (in_tdata[SENSOR_FRONT_RIGHT*SAMPLE_BITS +: SAMPLE_BITS] >
     in_tdata[SENSOR_FRONT_LEFT*SAMPLE_BITS +: SAMPLE_BITS]);

  assign flags_nxt = {lane_is_max, lane_above, front_right_gt, left_sum_gt};

  assign in_tready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      flags_r <= flags_nxt;
    end
  end

  wfrc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .flags      (flags_r),
    .cfg        (cfg_r),
    .s2_ready   (s2_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[src/wfrc_checker.sv]
// Port-level checks of the controller results, bound to the top level.
module wfrc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic [wfrc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wfrc_pkg::*;

  logic [OUT_SPEED_W-1:0] left, right;
  logic [2:0]             layer;

  assign left  = out_tdata[10:0];
  assign right = out_tdata[21:11];
  assign layer = out_tdata[26:24];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_spin_opposed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (layer == LAYER_ESCAPE || layer == LAYER_CORNER ||
                   layer == LAYER_OBSTACLE)
    |-> (OUT_SPEED_W'(left + right) == '0))
    else $error("turning layer with wheels not opposed");

  a_cruise_straight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (layer == LAYER_CRUISE) |-> (left == right))
    else $error("cruise with unequal wheel speeds");

  a_seek_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (layer == LAYER_SEEK) |-> (!left[10] && !right[10]))
    else $error("seek with a reversing wheel");

endmodule

bind wall_follow_reactive_controller_top wfrc_checker u_wfrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tdata  (out_tdata)
);
